@@ design/ffpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants for the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int NUM_PARTITIONS = 64;
	localparam int SIZE_BITS      = 16;

	localparam int ADDR_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam int CNT_W  = $clog2(NUM_PARTITIONS + 1);
	localparam int SUM_W  = SIZE_BITS + ADDR_W;

	// transaction opcodes
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_REQ   = 2'd2;

	// result codes
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NOFIT  = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage
`default_nettype wire

@@ design/first_fit_partition_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// First-fit allocator over a table of variable partitions, with free space,
// largest hole and external-fragmentation tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode and size; output channel
//   (out_valid/out_ready) returns one result transaction per input.
//   Clear, add and rejected transactions go from accept straight to the done
//   state, which loads the output register and then returns to idle.
//   Requests with a nonzero size: one table entry is read per cycle through
//   the read port of the hole memory until blocks_loaded entries are read,
//   then the done state issues the result and returns to idle. The scan
//   updates the fitting hole and recomputes the largest hole in the same pass.
//   in_ready is high only while the sequencer is idle; a new transaction may
//   be accepted while a finished result still waits in the output register.
//   If the receiver stalls, the next result is held in the sequencer until
//   the output register frees up.
//   Reset clears the table count, sums and refusal history; hole memory
//   contents are left as is and never read beyond the loaded count.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [1:0]                          mode,
	input  wire  [ffpa_pkg::SIZE_BITS-1:0]      size,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [1:0]                          status,
	output logic [ffpa_pkg::ADDR_W-1:0]         block_index,
	output logic [ffpa_pkg::SUM_W-1:0]          total_free,
	output logic [ffpa_pkg::SIZE_BITS-1:0]      largest_free,
	output logic                                frag_exists,
	output logic [ffpa_pkg::CNT_W-1:0]          blocks_loaded
);
	import ffpa_pkg::*;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_PARTITIONS);

	logic [SIZE_BITS-1:0] mem [NUM_PARTITIONS];

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [SIZE_BITS-1:0] size_q;

	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SIZE_BITS-1:0] big_q;
	logic [SIZE_BITS-1:0] sref_q;
	logic                 anyref_q;

	// scan datapath
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 rd_vld_s1;
	logic [ADDR_W-1:0]    rd_addr_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 found_q;
	logic [ADDR_W-1:0]    hit_q;
	logic [SIZE_BITS-1:0] max_q;

	logic                 out_valid_q;

	logic                 accept;
	logic                 issue;
	logic                 fit;
	logic [SIZE_BITS-1:0] new_val;
	logic                 finish;

	logic                 we;
	logic [ADDR_W-1:0]    wa;
	logic [SIZE_BITS-1:0] wd;

	logic                 slot_free;
	logic [CNT_W-1:0]     cnt_n;
	logic [SUM_W-1:0]     sum_n;
	logic [SIZE_BITS-1:0] big_n;
	logic [SIZE_BITS-1:0] sref_n;
	logic                 anyref_n;
	logic [1:0]           status_n;
	logic [ADDR_W-1:0]    idx_n;
	logic                 add_ok;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
	assign finish   = (state_q == ST_SCAN) && !issue && !rd_vld_s1;

	assign fit      = rd_vld_s1 && !found_q && (rd_data_s1 >= size_q);
	assign new_val  = fit ? (rd_data_s1 - size_q) : rd_data_s1;

	assign slot_free = !out_valid_q || out_ready;
	assign add_ok    = (size_q != '0) && (cnt_q != CNT_FULL);

	// next architectural state, applied when the result is issued
	always_comb begin
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		big_n    = big_q;
		sref_n   = sref_q;
		anyref_n = anyref_q;
		status_n = STATUS_OK;
		idx_n    = '0;
		unique case (mode_q)
			MODE_CLEAR: begin
				cnt_n    = '0;
				sum_n    = '0;
				big_n    = '0;
				sref_n   = '1;
				anyref_n = 1'b0;
			end
			MODE_ADD: begin
				if (add_ok) begin
					cnt_n = cnt_q + 1'b1;
					sum_n = sum_q + {{ADDR_W{1'b0}}, size_q};
					if (size_q > big_q)
						big_n = size_q;
				end else begin
					status_n = STATUS_REJECT;
				end
			end
			MODE_REQ: begin
				if (size_q == '0) begin
					status_n = STATUS_REJECT;
				end else if (found_q) begin
					sum_n = sum_q - {{ADDR_W{1'b0}}, size_q};
					big_n = max_q;
					idx_n = hit_q;
				end else begin
					status_n = STATUS_NOFIT;
					if (!anyref_q || size_q < sref_q)
						sref_n = size_q;
					anyref_n = 1'b1;
				end
			end
			default: status_n = STATUS_REJECT;
		endcase
	end

	// single write port: scan write-back or append
	always_comb begin
		we = 1'b0;
		wa = rd_addr_s1;
		wd = new_val;
		if ((state_q == ST_SCAN) && fit) begin
			we = 1'b1;
		end else if ((state_q == ST_DONE) && slot_free && (mode_q == MODE_ADD) && add_ok) begin
			we = 1'b1;
			wa = cnt_q[ADDR_W-1:0];
			wd = size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
		rd_addr_s1 <= rd_idx_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			big_q       <= '0;
			sref_q      <= '1;
			anyref_q    <= 1'b0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q  <= '0;
						rd_vld_s1 <= 1'b0;
						found_q   <= 1'b0;
						if ((mode == MODE_REQ) && (size != '0))
							state_q <= ST_SCAN;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue;
					if (issue)
						rd_idx_q <= rd_idx_q + 1'b1;
					if (fit)
						found_q <= 1'b1;
					if (finish)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						cnt_q       <= cnt_n;
						sum_q       <= sum_n;
						big_q       <= big_n;
						sref_q      <= sref_n;
						anyref_q    <= anyref_n;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			size_q <= size;
			max_q  <= '0;
		end else if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (new_val > max_q)
				max_q <= new_val;
		end
		if ((state_q == ST_SCAN) && fit)
			hit_q <= rd_addr_s1;
		if ((state_q == ST_DONE) && slot_free) begin
			status        <= status_n;
			block_index   <= idx_n;
			total_free    <= sum_n;
			largest_free  <= big_n;
			frag_exists   <= anyref_n && ({{ADDR_W{1'b0}}, sref_n} <= sum_n);
			blocks_loaded <= cnt_n;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("partition count exceeds table depth");

	a_big_le_sum: assert property (@(posedge clk) disable iff (!arst_n)
		{{ADDR_W{1'b0}}, big_q} <= sum_q)
		else $error("largest hole exceeds total free space");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("sequencer idle right after accept");

	a_done_issues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && slot_free |=> out_valid)
		else $error("result not issued from done state");
`endif

endmodule
`default_nettype wire
